// ===== sv/spos_pkg.sv =====
// Shared types and constants for the slab page order selector.
// Used by the top level and by the port checker; depends on nothing else.
`default_nettype none

package spos_pkg;

	localparam int SIZE_W  = 24;
	localparam int ORDER_W = 4;
	localparam int OBJ_W   = 8;
	localparam int QUO_W   = OBJ_W + 1;
	localparam int ADDR_W  = 4;
	localparam int DATA_W  = 32;

	// Register indexes, taken from paddr[3:2].
	localparam logic [1:0] REG_LEAST    = 2'd0;
	localparam logic [1:0] REG_GREATEST = 2'd1;
	localparam logic [1:0] REG_WANTED   = 2'd2;

	localparam logic [ORDER_W-1:0] LEAST_RST    = 4'd0;
	localparam logic [ORDER_W-1:0] GREATEST_RST = 4'd3;
	localparam logic [OBJ_W-1:0]   WANTED_RST   = 8'd0;

	// Leftover limits as right shifts of the slab size: 1/16, 1/8, 1/4, whole slab.
	localparam logic [2:0] FRAC16_SH = 3'd4;
	localparam logic [2:0] FRAC8_SH  = 3'd3;
	localparam logic [2:0] FRAC4_SH  = 3'd2;
	localparam logic [2:0] FRAC1_SH  = 3'd0;

	localparam logic [1:0] FRAC_FIRST = 2'd0;
	localparam logic [1:0] FRAC_MID   = 2'd1;
	localparam logic [1:0] FRAC_LAST  = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_CAP,
		ST_BIG,
		ST_G_SEARCH,
		ST_DIV_REM,
		ST_DIV_FIT,
		ST_MUL_CNT,
		ST_WALK
	} state_t;

	typedef enum logic [1:0] {
		PH_GREEDY,
		PH_FB_TOP,
		PH_FB_LIMIT
	} phase_t;

	typedef struct packed {
		logic                fin;
		logic                found;
		logic [ORDER_W-1:0]  order;
	} result_t;

endpackage

`default_nettype wire

// ===== sv/spos_mul.sv =====
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// Standalone; instantiated by slab_page_order_select.
`default_nettype none

module spos_mul #(
	parameter int A_W = 24,
	parameter int B_W = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [A_W-1:0]     a,
	input  wire logic [B_W-1:0]     b,
	output logic                    done,
	output logic [A_W+B_W-1:0]      prod
);

	localparam int CNT_W = $clog2(B_W + 1);

	logic [A_W-1:0]     a_q;
	logic [B_W-1:0]     b_q;
	logic [A_W+B_W-1:0] acc_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               run_q;
	logic               done_q;
	logic [A_W:0]       sum;

	assign sum = {1'b0, acc_q[A_W+B_W-1:B_W]} + (b_q[0] ? {1'b0, a_q} : {(A_W+1){1'b0}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(B_W);
		end else if (run_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// The partial sum enters at the top and the product shifts down one bit a cycle.
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (run_q) begin
			b_q   <= b_q >> 1;
			acc_q <= {sum, acc_q[B_W-1:1]};
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

`default_nettype wire

// ===== sv/spos_div.sv =====
// Bit-serial restoring divider for a power of two by a variable divisor.
// Gives the remainder and a quotient that saturates; used by slab_page_order_select.
`default_nettype none

module spos_div #(
	parameter int D_W   = 24,
	parameter int STEPS = 28,
	parameter int Q_W   = 9
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [D_W-1:0]            d,
	input  wire logic [$clog2(STEPS)-1:0]  n,
	output logic                           done,
	output logic [Q_W-1:0]                 quo,
	output logic [D_W-1:0]                 rem
);

	localparam int I_W = $clog2(STEPS);

	logic [D_W-1:0] d_q;
	logic [I_W-1:0] n_q;
	logic [I_W-1:0] i_q;
	logic [D_W-1:0] r_q;
	logic [Q_W-1:0] q_q;
	logic           run_q;
	logic           done_q;
	logic [D_W:0]   rs;
	logic           ge;
	logic [D_W:0]   rn;

	// The dividend is 2**n, so its only set bit is the one at position n.
	assign rs = {r_q, (i_q == n_q)};
	assign ge = (rs >= {1'b0, d_q});
	assign rn = ge ? (rs - {1'b0, d_q}) : rs;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			i_q    <= I_W'(STEPS - 1);
		end else if (run_q) begin
			i_q <= i_q - 1'b1;
			if (i_q == '0) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Once the top quotient bit is set the quotient holds: callers only need to know it is large.
	always_ff @(posedge clk) begin
		if (start) begin
			d_q <= d;
			n_q <= n;
			r_q <= '0;
			q_q <= '0;
		end else if (run_q) begin
			r_q <= rn[D_W-1:0];
			q_q <= q_q[Q_W-1] ? q_q : {q_q[Q_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = q_q;
	assign rem  = r_q;

endmodule

`default_nettype wire

// ===== sv/slab_page_order_select.sv =====
// Slab page order selector: one request gives one page order, or a not-found flag.
// Setup runs the serial multiplier and divider, then the walk tries orders in turn: up to
// 3*(count-1)+1 walks of greatest-least+1 orders and one of ORDER_LIMIT-least.
// One request at a time: busy is high from acceptance until the one-cycle result strobe.
// Reset puts the registers at 0, 3, 0 and the sequencer at idle.
`default_nettype none

module slab_page_order_select #(
	parameter int PAGE_BITS       = 12,
	parameter int ORDER_LIMIT     = 11,
	parameter int OBJECTS_CAP     = 32767,
	parameter int DEFAULT_OBJECTS = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [spos_pkg::ADDR_W-1:0]    paddr,
	input  wire logic [spos_pkg::DATA_W-1:0]    pwdata,
	output logic [spos_pkg::DATA_W-1:0]         prdata,
	output logic                                pready,
	input  wire logic                           start,
	output logic                                busy,
	input  wire logic [spos_pkg::SIZE_W-1:0]    object_bytes,
	output logic                                done,
	output logic [spos_pkg::ORDER_W-1:0]        page_order,
	output logic                                order_found
);

	import spos_pkg::*;

	localparam int CAP_W     = $clog2(OBJECTS_CAP + 1);
	localparam int MUL_BW    = (CAP_W > OBJ_W) ? CAP_W : OBJ_W;
	localparam int PROD_W    = SIZE_W + MUL_BW;
	localparam int PM1_W     = SIZE_W + OBJ_W;
	localparam int DIV_STEPS = PAGE_BITS + 16;
	localparam int SH_W      = $clog2(DIV_STEPS);

	localparam logic [SH_W-1:0]    PB_SH     = SH_W'(PAGE_BITS);
	localparam logic [MUL_BW-1:0]  CAP_B     = MUL_BW'(OBJECTS_CAP);
	localparam logic [ORDER_W-1:0] LIMIT_TOP = ORDER_W'(ORDER_LIMIT - 1);
	localparam logic [ORDER_W:0]   LIMIT_O   = (ORDER_W + 1)'(ORDER_LIMIT);
	localparam logic [OBJ_W-1:0]   DEF_OBJ   = OBJ_W'(DEFAULT_OBJECTS);

	function automatic logic le_pow2(input logic [SIZE_W-1:0] v, input logic [SH_W-1:0] e);
		logic [SIZE_W-1:0] p;
		begin
			p = SIZE_W'(1) << e;
			if (int'(e) >= SIZE_W)
				return 1'b1;
			return ((v >> e) == '0) || (v == p);
		end
	endfunction

	// Configuration registers
	logic [ORDER_W-1:0] least_q;
	logic [ORDER_W-1:0] greatest_q;
	logic [OBJ_W-1:0]   wanted_q;
	logic               cfg_wr;
	logic [1:0]         reg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign reg_idx = paddr[ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			least_q    <= LEAST_RST;
			greatest_q <= GREATEST_RST;
			wanted_q   <= WANTED_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_LEAST:    least_q    <= pwdata[ORDER_W-1:0];
				REG_GREATEST: greatest_q <= pwdata[ORDER_W-1:0];
				REG_WANTED:   wanted_q   <= pwdata[OBJ_W-1:0];
				default:      ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_LEAST:    prdata = DATA_W'(least_q);
			REG_GREATEST: prdata = DATA_W'(greatest_q);
			REG_WANTED:   prdata = DATA_W'(wanted_q);
			default:      prdata = '0;
		endcase
	end

	// Sequencer and datapath registers
	state_t              state_q, state_d;
	phase_t              phase_q, phase_d;
	logic [1:0]          fidx_q, fidx_d;
	logic [SIZE_W-1:0]   size_q;
	logic [PROD_W-1:0]   sc_q;
	logic [ORDER_W-1:0]  k_q, k_d;
	logic [SIZE_W-1:0]   rem_lo_q, rem_d;
	logic [OBJ_W-1:0]    cnt_q, cnt_d;
	logic [PM1_W-1:0]    pm1_q, pm1_d;
	logic [ORDER_W-1:0]  ord_q, ord_d;
	logic [SIZE_W-1:0]   r_q, r_d;
	logic                done_q;
	logic [ORDER_W-1:0]  page_order_q;
	logic                order_found_q;
	result_t             res;

	// Serial units
	logic                mul_start;
	logic [SIZE_W-1:0]   mul_a;
	logic [MUL_BW-1:0]   mul_b;
	logic                mul_done;
	logic [PROD_W-1:0]   mul_prod;
	logic                div_start;
	logic [SH_W-1:0]     div_n;
	logic                div_done;
	logic [QUO_W-1:0]    div_quo;
	logic [SIZE_W-1:0]   div_rem;

	assign mul_a = (state_q == ST_IDLE) ? object_bytes : size_q;

	spos_mul #(
		.A_W (SIZE_W),
		.B_W (MUL_BW)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	spos_div #(
		.D_W   (SIZE_W),
		.STEPS (DIV_STEPS),
		.Q_W   (QUO_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.d      (size_q),
		.n      (div_n),
		.done   (div_done),
		.quo    (div_quo),
		.rem    (div_rem)
	);

	// Checks on the current step
	logic [SH_W-1:0]     sh_lo, sh_top, sh_k, sh_ord, frac_e;
	logic [PROD_W:0]     scp_m1;
	logic [PROD_W-1:0]   sc_m1;
	logic                big, gcond;
	logic [OBJ_W-1:0]    count0, cnt_fit;
	logic [ORDER_W-1:0]  bound, x_ord;
	logic [2:0]          fsh;
	logic                slab_ok, frac_ok, pass;
	logic [SIZE_W:0]     r2, r2_red;

	assign sh_lo  = PB_SH + SH_W'(least_q);
	assign sh_top = PB_SH + SH_W'(greatest_q);
	assign sh_k   = PB_SH + SH_W'(k_q);
	assign sh_ord = PB_SH + SH_W'(ord_q);

	// More than the cap fits at least_order exactly when size * (cap + 1) fits in that slab.
	assign scp_m1 = {1'b0, sc_q} + (PROD_W + 1)'(size_q) - 1'b1;
	assign big    = ((scp_m1 >> sh_lo) == '0);
	assign sc_m1  = sc_q - 1'b1;
	assign gcond  = ((sc_m1 >> sh_k) == '0);
	assign x_ord  = k_q - 1'b1;

	assign count0  = (wanted_q == '0) ? DEF_OBJ : wanted_q;
	assign cnt_fit = div_quo[OBJ_W] ? count0 :
	                 ((div_quo[OBJ_W-1:0] < count0) ? div_quo[OBJ_W-1:0] : count0);

	assign bound = (phase_q == PH_FB_LIMIT) ? LIMIT_TOP : greatest_q;

	always_comb begin
		if (phase_q != PH_GREEDY) begin
			fsh = FRAC1_SH;
		end else begin
			unique case (fidx_q)
				FRAC_FIRST: fsh = FRAC16_SH;
				FRAC_MID:   fsh = FRAC8_SH;
				default:    fsh = FRAC4_SH;
			endcase
		end
	end

	assign frac_e  = sh_ord - SH_W'(fsh);
	assign slab_ok = ((pm1_q >> sh_ord) == '0);
	assign frac_ok = le_pow2(r_q, frac_e);
	assign pass    = (ord_q <= bound) && slab_ok && frac_ok;

	// Leftover of the next larger slab: double and reduce once.
	assign r2     = {r_q, 1'b0};
	assign r2_red = (r2 >= {1'b0, size_q}) ? (r2 - {1'b0, size_q}) : r2;

	always_comb begin
		state_d   = state_q;
		phase_d   = phase_q;
		fidx_d    = fidx_q;
		k_d       = k_q;
		rem_d     = rem_lo_q;
		cnt_d     = cnt_q;
		pm1_d     = pm1_q;
		ord_d     = ord_q;
		r_d       = r_q;
		res       = '0;
		mul_start = 1'b0;
		mul_b     = CAP_B;
		div_start = 1'b0;
		div_n     = sh_lo;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					mul_start = 1'b1;
					state_d   = ST_MUL_CAP;
				end
			end
			ST_MUL_CAP: begin
				if (mul_done)
					state_d = ST_BIG;
			end
			ST_BIG: begin
				if (size_q == '0) begin
					res.fin = 1'b1;
					state_d = ST_IDLE;
				end else if (big) begin
					k_d     = '0;
					state_d = ST_G_SEARCH;
				end else begin
					div_start = 1'b1;
					div_n     = sh_lo;
					state_d   = ST_DIV_REM;
				end
			end
			ST_G_SEARCH: begin
				if (gcond || (k_q == least_q)) begin
					res.fin = 1'b1;
					state_d = ST_IDLE;
					// The order is one below the smallest slab that holds cap objects.
					if (k_q != '0) begin
						if ((x_ord <= greatest_q) || ({1'b0, x_ord} < LIMIT_O)) begin
							res.found = 1'b1;
							res.order = x_ord;
						end
					end
				end else begin
					k_d = k_q + 1'b1;
				end
			end
			ST_DIV_REM: begin
				if (div_done) begin
					rem_d     = div_rem;
					div_start = 1'b1;
					div_n     = sh_top;
					state_d   = ST_DIV_FIT;
				end
			end
			ST_DIV_FIT: begin
				if (div_done) begin
					cnt_d = cnt_fit;
					ord_d = least_q;
					r_d   = rem_lo_q;
					if (cnt_fit >= OBJ_W'(2)) begin
						mul_start = 1'b1;
						mul_b     = MUL_BW'(cnt_fit);
						state_d   = ST_MUL_CNT;
					end else begin
						pm1_d   = PM1_W'(size_q) - 1'b1;
						phase_d = PH_FB_TOP;
						state_d = ST_WALK;
					end
				end
			end
			ST_MUL_CNT: begin
				if (mul_done) begin
					pm1_d   = mul_prod[PM1_W-1:0] - 1'b1;
					phase_d = PH_GREEDY;
					fidx_d  = FRAC_FIRST;
					ord_d   = least_q;
					r_d     = rem_lo_q;
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				if (pass) begin
					res.fin   = 1'b1;
					res.found = 1'b1;
					res.order = ord_q;
					state_d   = ST_IDLE;
				end else if (ord_q >= bound) begin
					ord_d = least_q;
					r_d   = rem_lo_q;
					unique case (phase_q)
						PH_GREEDY: begin
							if (fidx_q != FRAC_LAST) begin
								fidx_d = fidx_q + 1'b1;
							end else begin
								// Next smaller object count: the product drops by one size.
								fidx_d = FRAC_FIRST;
								cnt_d  = cnt_q - 1'b1;
								pm1_d  = pm1_q - PM1_W'(size_q);
								if (cnt_q == OBJ_W'(2))
									phase_d = PH_FB_TOP;
							end
						end
						PH_FB_TOP: begin
							phase_d = PH_FB_LIMIT;
						end
						default: begin
							res.fin = 1'b1;
							state_d = ST_IDLE;
						end
					endcase
				end else begin
					ord_d = ord_q + 1'b1;
					r_d   = r2_red[SIZE_W-1:0];
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_GREEDY;
			fidx_q  <= FRAC_FIRST;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			fidx_q  <= fidx_d;
			done_q  <= res.fin;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && start)
			size_q <= object_bytes;
		if ((state_q == ST_MUL_CAP) && mul_done)
			sc_q <= mul_prod;
		k_q      <= k_d;
		rem_lo_q <= rem_d;
		cnt_q    <= cnt_d;
		pm1_q    <= pm1_d;
		ord_q    <= ord_d;
		r_q      <= r_d;
		if (res.fin) begin
			page_order_q  <= res.found ? res.order : '0;
			order_found_q <= res.found;
		end
	end

	assign busy        = (state_q != ST_IDLE);
	assign done        = done_q;
	assign page_order  = page_order_q;
	assign order_found = order_found_q;

endmodule

`default_nettype wire

// ===== sv/spos_chk.sv =====
// Port-level checker for the slab page order selector, bound to the top level.
// Depends on spos_pkg for field widths.
`default_nettype none

module spos_chk (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         start,
	input wire logic                         busy,
	input wire logic                         done,
	input wire logic [spos_pkg::ORDER_W-1:0] page_order,
	input wire logic                         order_found
);

	import spos_pkg::*;

	// An accepted request always occupies the block in the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("block not busy after an accepted request");

	// Work ends only with a result.
	a_result_on_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

	a_result_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while still busy");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_not_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !order_found) |-> (page_order == '0))
		else $error("nonzero order with no order found");

endmodule

bind slab_page_order_select spos_chk u_spos_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.page_order  (page_order),
	.order_found (order_found)
);

`default_nettype wire

// ===== bench/slab_page_order_select_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for slab_page_order_select: drives object sizes, writes the order
// registers over APB, and checks each page order against an in-bench predictor.
// Depends on spos_pkg and the slab_page_order_select RTL.

module slab_page_order_select_tb;

	localparam int PAGE_BITS       = 12;
	localparam int ORDER_LIMIT     = 11;
	localparam int OBJECTS_CAP     = 32767;
	localparam int DEFAULT_OBJECTS = 16;

	typedef struct {
		logic [spos_pkg::ORDER_W-1:0] order;
		logic                         found;
	} order_pick_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            psel = 1'b0;
	logic                            penable = 1'b0;
	logic                            pwrite = 1'b0;
	logic [spos_pkg::ADDR_W-1:0]     paddr = '0;
	logic [spos_pkg::DATA_W-1:0]     pwdata = '0;
	logic [spos_pkg::DATA_W-1:0]     prdata;
	logic                            pready;
	logic                            start = 1'b0;
	logic                            busy;
	logic [spos_pkg::SIZE_W-1:0]     object_bytes = '0;
	logic                            done;
	logic [spos_pkg::ORDER_W-1:0]    page_order;
	logic                            order_found;

	// Register copies kept by the predictor.
	logic [spos_pkg::ORDER_W-1:0]    cfg_least    = spos_pkg::LEAST_RST;
	logic [spos_pkg::ORDER_W-1:0]    cfg_greatest = spos_pkg::GREATEST_RST;
	logic [spos_pkg::OBJ_W-1:0]      cfg_wanted   = spos_pkg::WANTED_RST;

	order_pick_t orders_due[$];
	int          mismatches = 0;
	bit          gaps_on = 1'b1;

	slab_page_order_select #(
		.PAGE_BITS      (PAGE_BITS),
		.ORDER_LIMIT    (ORDER_LIMIT),
		.OBJECTS_CAP    (OBJECTS_CAP),
		.DEFAULT_OBJECTS(DEFAULT_OBJECTS)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.start       (start),
		.busy        (busy),
		.object_bytes(object_bytes),
		.done        (done),
		.page_order  (page_order),
		.order_found (order_found)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ---------------------------------------------------------------- predictor

	function automatic int top_bit(logic [63:0] x);
		int n = 0;
		while (x != 0) begin
			n++;
			x = x >> 1;
		end
		return n;
	endfunction

	// Smallest order whose slab holds the given byte count.
	function automatic int order_to_hold(logic [63:0] nbytes);
		logic [63:0] s;
		int o;
		o = -1;
		if (nbytes == 0)
			nbytes = 1;
		s = (nbytes - 1) >> (PAGE_BITS - 1);
		do begin
			s = s >> 1;
			o++;
		end while (s != 0);
		return o;
	endfunction

	function automatic int walk_orders(logic [63:0] size, logic [63:0] count, int bound,
			logic [63:0] fract);
		logic [63:0] per_slab;
		logic [63:0] slab;
		int lo;
		int o;
		int first;
		lo = int'(cfg_least);
		per_slab = (64'd1 << (PAGE_BITS + lo)) / size;
		// A tiny object would overflow the count limit, so size the slab from the cap.
		if (per_slab > OBJECTS_CAP)
			return order_to_hold(size * OBJECTS_CAP) - 1;
		first = top_bit(count * size - 1) - PAGE_BITS;
		if (first < lo)
			first = lo;
		for (o = first; o <= bound; o++) begin
			slab = 64'd1 << (PAGE_BITS + o);
			if (slab < count * size)
				continue;
			if (slab % size <= slab / fract)
				break;
		end
		return o;
	endfunction

	function automatic order_pick_t predict_order(logic [spos_pkg::SIZE_W-1:0] obj);
		order_pick_t pick;
		logic [63:0] size;
		logic [63:0] count;
		logic [63:0] fit;
		logic [63:0] fract;
		int top;
		int o;
		size = 64'(obj);
		top = int'(cfg_greatest);
		o = -1;
		if (size != 0) begin
			count = (cfg_wanted == 0) ? 64'(DEFAULT_OBJECTS) : 64'(cfg_wanted);
			fit = (64'd1 << (PAGE_BITS + top)) / size;
			if (fit < count)
				count = fit;
			o = top + 1;
			while (count > 1 && o > top) begin
				fract = 16;
				while (fract >= 4 && o > top) begin
					o = walk_orders(size, count, top, fract);
					fract = fract / 2;
				end
				if (o > top)
					count--;
			end
			if (o > top) begin
				// One object per slab, first within the preferred bound, then the hard one.
				o = walk_orders(size, 1, top, 1);
				if (o > top) begin
					o = walk_orders(size, 1, ORDER_LIMIT, 1);
					if (o >= ORDER_LIMIT)
						o = -1;
				end
			end
		end
		if (o < 0) begin
			pick.order = '0;
			pick.found = 1'b0;
		end else begin
			pick.order = o[spos_pkg::ORDER_W-1:0];
			pick.found = 1'b1;
		end
		return pick;
	endfunction

	// ---------------------------------------------------------------- drivers

	task automatic request_order(input logic [spos_pkg::SIZE_W-1:0] obj);
		@(negedge clk);
		while (gaps_on && $urandom_range(99) < 29)
			@(negedge clk);
		start <= 1'b1;
		object_bytes <= obj;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		orders_due.push_back(predict_order(obj));
		@(negedge clk);
		start <= 1'b0;
	endtask

	task automatic wait_drained;
		while (orders_due.size() != 0 || busy)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
		wait_drained();
		repeat (4) @(posedge clk);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		// Upper data bits are junk; the register keeps only its own width.
		pwdata  <= {16'($urandom_range(16'hFFFF)), 8'h00, value};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		case (idx)
			spos_pkg::REG_LEAST:    cfg_least    = value[spos_pkg::ORDER_W-1:0];
			spos_pkg::REG_GREATEST: cfg_greatest = value[spos_pkg::ORDER_W-1:0];
			spos_pkg::REG_WANTED:   cfg_wanted   = value;
			default: ;
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic set_orders(input int least, input int greatest, input int wanted);
		write_reg(spos_pkg::REG_LEAST, 8'(least));
		write_reg(spos_pkg::REG_GREATEST, 8'(greatest));
		write_reg(spos_pkg::REG_WANTED, 8'(wanted));
	endtask

	// Sizes spread over every bit width, with extra weight near powers of two.
	function automatic logic [spos_pkg::SIZE_W-1:0] random_size();
		int k;
		logic [spos_pkg::SIZE_W-1:0] v;
		case ($urandom_range(9))
			0: v = 24'($urandom_range(1, 64));
			1: v = 24'((24'd1 << $urandom_range(spos_pkg::SIZE_W - 1)) +
				$urandom_range(2) - 1);
			2: v = ($urandom_range(20) == 0) ? '0 : 24'($urandom_range(1, 4096));
			default: begin
				k = $urandom_range(1, spos_pkg::SIZE_W);
				v = 24'($urandom) & ((24'd1 << k) - 1);
				v[k-1] = 1'b1;
			end
		endcase
		return v;
	endfunction

	function automatic int random_order_reg();
		return ($urandom_range(7) == 0) ? $urandom_range(11, 15) : $urandom_range(10);
	endfunction

	// ---------------------------------------------------------------- result checker

	always @(posedge clk) begin
		order_pick_t want;
		if (arst_n && done) begin
			if (orders_due.size() == 0) begin
				$display("%0t: result with no request pending: order %0d found %0b", $time,
					page_order, order_found);
				mismatches++;
			end else begin
				want = orders_due.pop_front();
				if (page_order !== want.order) begin
					$display("%0t: page_order expected %0d, got %0d", $time, want.order,
						page_order);
					mismatches++;
				end
				if (order_found !== want.found) begin
					$display("%0t: order_found expected %0b, got %0b", $time, want.found,
						order_found);
					mismatches++;
				end
			end
		end
	end

	// ---------------------------------------------------------------- tests

	task automatic test_default_sizes;
		logic [spos_pkg::SIZE_W-1:0] sizes[11];
		sizes = '{24'd0, 24'd1, 24'd2, 24'd8, 24'd64, 24'd1000, 24'd4095, 24'd4096,
			24'd4097, 24'd8388608, 24'hFFFFFF};
		foreach (sizes[i])
			request_order(sizes[i]);
	endtask

	// Corner settings: tiny and full registers, values above ten, least above greatest,
	// and huge objects where the count cap drops below two.
	task automatic test_register_extremes;
		int settings[5][3];
		logic [spos_pkg::SIZE_W-1:0] sizes[3];
		settings = '{'{0, 0, 1}, '{15, 15, 255}, '{10, 10, 0}, '{5, 0, 2}, '{0, 10, 255}};
		sizes = '{24'd1, 24'd3000, 24'hFFFFFF};
		foreach (settings[s]) begin
			set_orders(settings[s][0], settings[s][1], settings[s][2]);
			foreach (sizes[i])
				request_order(sizes[i]);
		end
	endtask

	task automatic test_random_sizes;
		int wanted;
		for (int phase = 0; phase < 6; phase++) begin
			case ($urandom_range(3))
				0: wanted = 0;
				1: wanted = $urandom_range(1, 4);
				default: wanted = $urandom_range(255);
			endcase
			set_orders(random_order_reg(), random_order_reg(), wanted);
			gaps_on = (phase != 2);
			for (int i = 0; i < 13; i++) begin
				// Let the block run dry once before sending more.
				if (phase == 3 && i == 8)
					wait_drained();
				request_order(random_size());
			end
		end
		gaps_on = 1'b1;
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_default_sizes();
		test_register_extremes();
		test_random_sizes();
		wait_drained();
		repeat (20) @(posedge clk);
		if (orders_due.size() != 0)
			mismatches++;
		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin
		#1_500_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
